// File: hw/rtl/cwpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwpe_pkg
// Shared types and constants of the congestion window pacing engine.
// ----------------------------------------------------------------------------
package cwpe_pkg;

	localparam int MAX_WINDOW_SEGMENTS_DEF = 43;
	localparam int TIMEOUT_RESET_LIMIT_DEF = 100;

	localparam int WIN_W  = 20;
	localparam int TIME_W = 48;
	localparam int SEG_W  = 14;
	localparam int PROD_W = 128;
	localparam int MPL_W  = 64;

	localparam logic [WIN_W-1:0]  WINDOW_MAX      = 20'hFFFFF;
	localparam logic [WIN_W-1:0]  MIN_WINDOW      = 20'd15;
	localparam logic [TIME_W-1:0] TIME_MAX        = 48'hFFFF_FFFF_FFFF;
	localparam logic [33:0]       BITS_NS_SCALE   = 34'd8000000000;
	localparam logic [12:0]       RECIP_100       = 13'd5243;   // 2^19/100, rounded up
	localparam logic [7:0]        DUP_THRESHOLD   = 8'd3;
	localparam logic [6:0]        TIMEOUT_SAT     = 7'd127;

	localparam logic [2:0] ACT_ACK     = 3'd0;
	localparam logic [2:0] ACT_DUP     = 3'd1;
	localparam logic [2:0] ACT_QUENCH  = 3'd2;
	localparam logic [2:0] ACT_TIMEOUT = 3'd3;
	localparam logic [2:0] ACT_RTT     = 3'd4;

	localparam logic [2:0] SEND_NOW       = 3'd0;
	localparam logic [2:0] SEND_PACE      = 3'd1;
	localparam logic [2:0] SEND_RETX      = 3'd2;
	localparam logic [2:0] SEND_PACE_RETX = 3'd3;
	localparam logic [2:0] SEND_NONE      = 3'd4;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_SRC_RTT = 2'd1;
	localparam logic [1:0] ERR_RTT     = 2'd2;

	localparam logic [2:0] REG_SEGMENT  = 3'd0;
	localparam logic [2:0] REG_DECREASE = 3'd1;
	localparam logic [2:0] REG_ADDITIVE = 3'd2;
	localparam logic [2:0] REG_FR_OFF   = 3'd3;
	localparam logic [2:0] REG_LINK     = 3'd4;

	typedef struct packed {
		logic start;
		logic div;
	} mdu_req_t;

endpackage

// File: hw/rtl/cwpe_mdu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwpe_mdu
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module cwpe_mdu import cwpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mdu_req_t          req,
	input  logic [PROD_W-1:0] opa,
	input  logic [MPL_W-1:0]  opb,
	output logic              busy,
	output logic [PROD_W-1:0] res
);

	logic              busy_q;
	logic              div_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mc_q;
	logic [MPL_W-1:0]  mp_q;
	logic [WIN_W-1:0]  rem_q;
	logic [5:0]        cnt_q;

	logic [WIN_W:0] rem_sh;
	logic           ge;
	logic [WIN_W:0] rem_sub;

	assign rem_sh  = {rem_q, mp_q[MPL_W-1]};
	assign ge      = rem_sh >= {1'b0, mc_q[WIN_W-1:0]};
	assign rem_sub = rem_sh - {1'b0, mc_q[WIN_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			div_q  <= req.div;
		end else if (busy_q) begin
			if (div_q) begin
				if (cnt_q == 6'd63) busy_q <= 1'b0;
			end else if (mp_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mc_q  <= opa;
			mp_q  <= opb;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
				mp_q  <= {mp_q[MPL_W-2:0], ge};
				cnt_q <= cnt_q + 6'd1;
			end else if (mp_q != '0) begin
				if (mp_q[0]) acc_q <= acc_q + mc_q;
				mc_q <= {mc_q[PROD_W-2:0], 1'b0};
				mp_q <= {1'b0, mp_q[MPL_W-1:1]};
			end
		end
	end

	assign busy = busy_q;
	assign res  = div_q ? {{(PROD_W-MPL_W){1'b0}}, mp_q} : acc_q;

endmodule

// File: hw/rtl/congestion_window_pacing_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congestion_window_pacing_engine
// Per-flow congestion window with pacing delay; one event in, one result out.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid / in_stall  action now dup_count inc_flag ack_number ...
//  out       out_valid / out_stall window_bytes pace_delay send_action error_code
//  cfg       cfg_we               cfg_idx cfg_data
//
// Pacing division runs on the bit-serial divider. Source quench adds three
// serial multiplies, all on the one shared multiply/divide unit. in_stall is
// high from transfer to result load.
// Reset restores registers and flow state. A stalled result holds in the output
// register while the next event is taken.
module congestion_window_pacing_engine import cwpe_pkg::*; #(
	parameter int MAX_WINDOW_SEGMENTS = MAX_WINDOW_SEGMENTS_DEF,
	parameter int TIMEOUT_RESET_LIMIT = TIMEOUT_RESET_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [39:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [47:0] now,
	input  logic [7:0]  dup_count,
	input  logic        inc_flag,
	input  logic [31:0] ack_number,
	input  logic [31:0] next_seq,
	input  logic [47:0] sent_time,
	input  logic [15:0] link_util,
	input  logic [15:0] queue_packets,
	input  logic [47:0] echo_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] window_bytes,
	output logic [47:0] pace_delay,
	output logic [2:0]  send_action,
	output logic [1:0]  error_code
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PRE  = 4'd1;
	localparam logic [3:0] S_QLW  = 4'd2;
	localparam logic [3:0] S_QR1W = 4'd3;
	localparam logic [3:0] S_QR2W = 4'd4;
	localparam logic [3:0] S_SET  = 4'd5;
	localparam logic [3:0] S_DIVW = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	// configuration
	logic [SEG_W-1:0] seg_q;
	logic [15:0]      df_q;
	logic [15:0]      as_q;
	logic             fro_q;
	logic [39:0]      lr_q;

	// flow state
	logic [WIN_W-1:0]  window_q;
	logic [TIME_W-1:0] last_rtt_q;
	logic [TIME_W-1:0] ldt_q;
	logic [TIME_W-1:0] lqd_q;
	logic [6:0]        tc_q;
	logic [31:0]       mark_q;

	// captured event
	logic [2:0]  act_q;
	logic [47:0] now_q;
	logic [7:0]  dup_q;
	logic        inc_q;
	logic [31:0] ack_q;
	logic [31:0] nseq_q;
	logic [47:0] sent_q;
	logic [15:0] util_q;
	logic [15:0] queue_q;
	logic [47:0] echo_q;

	logic [3:0]        state_q;
	logic [22:0]       w_q;
	logic              dec_q;
	logic [PROD_W-1:0] lhs_q;
	logic [TIME_W-1:0] delay_q;
	logic [1:0]        err_q;

	logic        out_valid_q;
	logic [19:0] out_win_q;
	logic [47:0] out_delay_q;
	logic [2:0]  out_send_q;
	logic [1:0]  out_err_q;

	// datapath
	logic [SEG_W-1:0]  m;
	logic              allowed;
	logic [36:0]       sprod;
	logic [WIN_W-1:0]  scaled;
	logic [29:0]       aprod;
	logic [21:0]       addv;
	logic [26:0]       d100;
	logic [20:0]       capr;
	logic [WIN_W-1:0]  cap;
	logic [6:0]        tc_n;
	logic [61:0]       rtt_m;
	logic [53:0]       w8;
	logic [31:0]       qu;
	logic              qcond;
	logic              pre_quench;
	logic              set_div;
	logic [22:0]       w_ack;
	logic [22:0]       ws;
	logic [22:0]       wc;
	logic [2:0]        send_n;

	mdu_req_t          mreq;
	logic [PROD_W-1:0] mopa;
	logic [MPL_W-1:0]  mopb;
	logic              mbusy;
	logic [PROD_W-1:0] mres;

	assign m       = (seg_q == '0) ? SEG_W'(1) : seg_q;
	assign allowed = (ldt_q == '0) || ((now_q >= ldt_q) && ((now_q - ldt_q) >= last_rtt_q));
	assign sprod   = 37'(window_q) * 37'(17'h10000 - {1'b0, df_q});
	assign scaled  = sprod[35:16];
	assign aprod   = 30'(as_q) * 30'(m);
	assign addv    = aprod[29:8];
	assign d100    = 27'(m) * 27'(RECIP_100);
	assign capr    = 21'(m) * 21'(7'(MAX_WINDOW_SEGMENTS));
	assign cap     = (capr > {1'b0, WINDOW_MAX}) ? WINDOW_MAX : capr[19:0];
	assign tc_n    = (tc_q == TIMEOUT_SAT) ? tc_q : tc_q + 7'd1;
	assign rtt_m   = 62'(last_rtt_q) * 62'(m);
	assign w8      = {34'b0, window_q} * {20'b0, BITS_NS_SCALE};
	assign qu      = 32'(queue_q) * 32'(util_q);
	assign qcond   = (queue_q != '0) && (util_q != '0) && (now_q >= lqd_q);
	assign pre_quench = (act_q == ACT_QUENCH) && (window_q > 20'(m)) &&
		(now_q >= sent_q) && qcond;
	assign set_div = (w_q < 23'(m)) && (w_q != '0);
	assign w_ack   = 23'(window_q) + (inc_q ? 23'(m) : 23'd0) +
		((ack_q > mark_q) ? 23'(addv) : 23'd0);
	assign ws      = ((w_q < 23'(m)) && (delay_q == '0)) ? 23'(m) : w_q;
	assign wc      = (ws > 23'(cap)) ? 23'(cap) :
		((ws < 23'(MIN_WINDOW)) ? 23'(MIN_WINDOW) : ws);

	// operand select for the shared unit
	always_comb begin
		mreq = '0;
		mopa = '0;
		mopb = '0;
		case (state_q)
			S_PRE: begin
				if (pre_quench) begin
					mreq.start = 1'b1;
					mopa = (last_rtt_q != '0) ? PROD_W'(w8) : PROD_W'(lr_q);
					mopb = MPL_W'(now_q - sent_q);
				end
			end
			S_QLW: begin
				if (!mbusy) begin
					mreq.start = 1'b1;
					mopa = (last_rtt_q != '0) ? PROD_W'(last_rtt_q) : PROD_W'(1);
					mopb = MPL_W'(now_q - lqd_q);
				end
			end
			S_QR1W: begin
				if (!mbusy) begin
					mreq.start = 1'b1;
					mopa = mres;
					mopb = MPL_W'(qu);
				end
			end
			S_SET: begin
				if (set_div) begin
					mreq.start = 1'b1;
					mreq.div   = 1'b1;
					mopa = PROD_W'(w_q);
					mopb = MPL_W'(rtt_m);
				end
			end
			default: begin
			end
		endcase
	end

	cwpe_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.opa    (mopa),
		.opb    (mopb),
		.busy   (mbusy),
		.res    (mres)
	);

	always_comb begin
		case (act_q)
			ACT_ACK:     send_n = (delay_q != '0) ? SEND_PACE : SEND_NOW;
			ACT_DUP: begin
				if (fro_q)
					send_n = SEND_NONE;
				else if (dup_q == DUP_THRESHOLD)
					send_n = (delay_q != '0) ? SEND_PACE_RETX : SEND_RETX;
				else
					send_n = (delay_q != '0) ? SEND_NONE : SEND_NOW;
			end
			ACT_TIMEOUT: send_n = (delay_q != '0) ? SEND_PACE_RETX : SEND_RETX;
			default:     send_n = SEND_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= 14'd1460;
			df_q  <= 16'd32768;
			as_q  <= 16'd256;
			fro_q <= 1'b0;
			lr_q  <= 40'd100000000000;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SEGMENT:  seg_q <= cfg_data[13:0];
				REG_DECREASE: df_q  <= cfg_data[15:0];
				REG_ADDITIVE: as_q  <= cfg_data[15:0];
				REG_FR_OFF:   fro_q <= cfg_data[0];
				REG_LINK:     lr_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			act_q   <= action;
			now_q   <= now;
			dup_q   <= dup_count;
			inc_q   <= inc_flag;
			ack_q   <= ack_number;
			nseq_q  <= next_seq;
			sent_q  <= sent_time;
			util_q  <= link_util;
			queue_q <= queue_packets;
			echo_q  <= echo_time;
		end
		if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
			out_win_q   <= window_q;
			out_delay_q <= delay_q;
			out_send_q  <= send_n;
			out_err_q   <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			window_q    <= 20'd1460;
			last_rtt_q  <= '0;
			ldt_q       <= '0;
			lqd_q       <= '0;
			tc_q        <= '0;
			mark_q      <= '0;
			w_q         <= '0;
			dec_q       <= 1'b0;
			lhs_q       <= '0;
			delay_q     <= '0;
			err_q       <= ERR_NONE;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_PRE;
				end
				S_PRE: begin
					delay_q <= '0;
					err_q   <= ERR_NONE;
					dec_q   <= 1'b0;
					w_q     <= 23'(window_q);
					state_q <= S_SET;
					case (act_q)
						ACT_ACK: begin
							tc_q <= '0;
							if (dup_q >= DUP_THRESHOLD) begin
								if (!fro_q && allowed) begin
									w_q   <= 23'(scaled);
									dec_q <= 1'b1;
								end
							end else begin
								w_q <= w_ack;
								if (ack_q > mark_q) mark_q <= nseq_q;
							end
						end
						ACT_DUP: begin
							if (fro_q) begin
								state_q <= S_OUT;
							end else if (dup_q == DUP_THRESHOLD) begin
								dec_q <= 1'b1;
								if (allowed) w_q <= 23'(scaled);
							end else begin
								w_q <= 23'(window_q) + 23'(addv);
							end
						end
						ACT_QUENCH: begin
							dec_q <= 1'b1;
							if (window_q <= 20'(m)) begin
								w_q <= 23'(scaled);
							end else if (now_q < sent_q) begin
								err_q   <= ERR_SRC_RTT;
								state_q <= S_OUT;
							end else if (pre_quench) begin
								state_q <= S_QLW;
							end
						end
						ACT_TIMEOUT: begin
							tc_q <= tc_n;
							if (tc_n >= 7'(TIMEOUT_RESET_LIMIT)) begin
								w_q   <= 23'(d100[26:19]);
								dec_q <= 1'b1;
							end else if (allowed) begin
								w_q   <= 23'(scaled);
								dec_q <= 1'b1;
							end
						end
						ACT_RTT: begin
							if (echo_q >= now_q) err_q <= ERR_RTT;
							else last_rtt_q <= now_q - echo_q;
							state_q <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_QLW: begin
					if (!mbusy) begin
						lhs_q   <= mres;
						state_q <= S_QR1W;
					end
				end
				S_QR1W: begin
					if (!mbusy) state_q <= S_QR2W;
				end
				S_QR2W: begin
					if (!mbusy) begin
						if (lhs_q <= mres) begin
							w_q   <= w_q - 23'(m);
							lqd_q <= now_q;
						end
						state_q <= S_SET;
					end
				end
				S_SET: begin
					if (set_div) begin
						state_q <= S_DIVW;
					end else begin
						// empty window: saturate once an RTT is known
						delay_q <= (w_q == '0 && last_rtt_q != '0) ? TIME_MAX : '0;
						state_q <= S_FIN;
					end
				end
				S_DIVW: begin
					if (!mbusy) begin
						delay_q <= (mres[63:48] != '0) ? TIME_MAX : mres[47:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					window_q <= wc[19:0];
					if (dec_q) ldt_q <= now_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall     = state_q != S_IDLE;
	assign out_valid    = out_valid_q;
	assign window_bytes = out_win_q;
	assign pace_delay   = out_delay_q;
	assign send_action  = out_send_q;
	assign error_code   = out_err_q;

`ifndef ASSERT_OFF
	a_win_floor: assert property (@(posedge clk) disable iff (!arst_n)
		window_q >= MIN_WINDOW)
		else $error("window below floor");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside load state");

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mbusy)
		else $error("shared unit busy while idle");

	a_take_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_PRE)
		else $error("accepted event not started");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the congestion window pacing engine. Events go in
// through the valid/stall channel in random bursts while the result side
// stalls on its own pattern. A scoreboard class keeps its own flow state and
// register copy, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
	import cwpe_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [2:0]  act;
		logic [47:0] now;
		logic [7:0]  dups;
		logic        inc;
		logic [31:0] ackno;
		logic [31:0] nseq;
		logic [47:0] sent;
		logic [15:0] util;
		logic [15:0] queue;
		logic [47:0] echo;
	} flow_event_t;

	typedef struct {
		logic [19:0] win;
		logic [47:0] delay;
		logic [2:0]  send;
		logic [1:0]  err;
	} window_result_t;

	class window_scoreboard;
		bit [63:0] seg, dfrac, astep, froff, lrate;
		bit [63:0] win, lrtt, ldt, lqd, tcount, imark;
		window_result_t pending_q[$];
		int mismatches;
		int results_seen;
		int act_count[8];

		function new();
			seg = 1460; dfrac = 32768; astep = 256; froff = 0; lrate = 64'd100000000000;
			win = 1460; lrtt = 0; ldt = 0; lqd = 0; tcount = 0; imark = 0;
			mismatches = 0;
			results_seen = 0;
			foreach (act_count[i]) act_count[i] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [39:0] data);
			case (idx)
				REG_SEGMENT:  seg = 64'(data[13:0]);
				REG_DECREASE: dfrac = 64'(data[15:0]);
				REG_ADDITIVE: astep = 64'(data[15:0]);
				REG_FR_OFF:   froff = 64'(data[0]);
				REG_LINK:     lrate = 64'(data);
				default: ;
			endcase
		endfunction

		function bit [63:0] seg_bytes();
			return (seg == 0) ? 64'd1 : seg;
		endfunction

		function bit may_decrease(bit [63:0] t);
			if (ldt == 0) return 1;
			if (t < ldt) return 0;
			return (t - ldt) >= lrtt;
		endfunction

		function bit [63:0] shrink(bit [63:0] w);
			return (w * (64'd65536 - dfrac)) >> 16;
		endfunction

		function bit [63:0] grow_step();
			return (astep * seg_bytes()) >> 8;
		endfunction

		// clamps and stores the window, returns the pacing delay
		function bit [63:0] settle_window(bit [63:0] w, bit [63:0] t, bit decreased);
			bit [63:0] m, delay, cap, q;
			m = seg_bytes();
			delay = 0;
			if (decreased) ldt = t;
			if (w < m) begin
				if (w == 0) begin
					delay = (lrtt != 0) ? {16'd0, TIME_MAX} : 64'd0;
				end else begin
					q = (lrtt * m) / w;
					delay = (q > {16'd0, TIME_MAX}) ? {16'd0, TIME_MAX} : q;
				end
				if (delay == 0) w = m;
			end
			cap = MAX_WINDOW_SEGMENTS_DEF * m;
			if (cap > WINDOW_MAX) cap = WINDOW_MAX;
			if (w > cap) w = cap;
			if (w < MIN_WINDOW) w = MIN_WINDOW;
			win = w;
			return delay;
		endfunction

		function void note(flow_event_t e);
			bit [63:0] t, w, m, delay, rs;
			bit [127:0] lhs, rhs;
			bit [2:0] send;
			bit [1:0] err;
			bit dec, allowed;
			window_result_t r;
			t = 64'(e.now); w = win; m = seg_bytes();
			delay = 0; send = SEND_NONE; err = ERR_NONE; dec = 0;
			act_count[e.act]++;
			case (e.act)
				ACT_ACK: begin
					tcount = 0;
					if (e.dups >= DUP_THRESHOLD) begin
						if (!froff && may_decrease(t)) begin
							w = shrink(w);
							dec = 1;
						end
					end else begin
						if (e.inc) w += m;
						if (e.ackno > imark) begin
							w += grow_step();
							imark = 64'(e.nseq);
						end
					end
					delay = settle_window(w, t, dec);
					send = (delay > 0) ? SEND_PACE : SEND_NOW;
				end
				ACT_DUP: begin
					if (!froff) begin
						if (e.dups == DUP_THRESHOLD) begin
							if (may_decrease(t)) w = shrink(w);
							delay = settle_window(w, t, 1);
							send = (delay > 0) ? SEND_PACE_RETX : SEND_RETX;
						end else begin
							delay = settle_window(w + grow_step(), t, 0);
							send = (delay > 0) ? SEND_NONE : SEND_NOW;
						end
					end
				end
				ACT_QUENCH: begin
					if (w <= m) begin
						w = shrink(w);
					end else if (t < e.sent) begin
						err = ERR_SRC_RTT;
					end else begin
						rs = t - 64'(e.sent);
						if (lrtt != 0) begin
							lhs = 128'(rs) * 128'(w * 64'd8000000000);
							rhs = 128'(lrtt);
						end else begin
							lhs = 128'(rs) * 128'(lrate);
							rhs = 128'd1;
						end
						if (e.queue != 0 && e.util != 0 && t >= lqd) begin
							rhs = rhs * 128'(t - lqd);
							rhs = rhs * 128'(64'(e.queue) * 64'(e.util));
							if (lhs <= rhs) begin
								w -= m;
								lqd = t;
							end
						end
					end
					if (err == ERR_NONE) delay = settle_window(w, t, 1);
				end
				ACT_TIMEOUT: begin
					allowed = may_decrease(t);
					if (tcount < TIMEOUT_SAT) tcount++;
					if (tcount >= TIMEOUT_RESET_LIMIT_DEF) begin
						w = m / 100;
						dec = 1;
					end else if (allowed) begin
						w = shrink(w);
						dec = 1;
					end
					delay = settle_window(w, t, dec);
					send = (delay > 0) ? SEND_PACE_RETX : SEND_RETX;
				end
				ACT_RTT: begin
					if (e.echo >= e.now) err = ERR_RTT;
					else lrtt = t - 64'(e.echo);
				end
				default: ;
			endcase
			r.win = win[19:0];
			r.delay = delay[47:0];
			r.send = send;
			r.err = err;
			pending_q.push_back(r);
		endfunction

		function void check(window_result_t got);
			window_result_t exp_r;
			results_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: win=%0d delay=%0d send=%0d err=%0d",
						got.win, got.delay, got.send, got.err);
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.win !== exp_r.win || got.delay !== exp_r.delay ||
					got.send !== exp_r.send || got.err !== exp_r.err) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch #%0d: exp win=%0d delay=%0d send=%0d err=%0d",
						results_seen, exp_r.win, exp_r.delay, exp_r.send, exp_r.err);
					$display("    got win=%0d delay=%0d send=%0d err=%0d",
						got.win, got.delay, got.send, got.err);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [39:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [47:0] now;
	logic [7:0]  dup_count;
	logic        inc_flag;
	logic [31:0] ack_number;
	logic [31:0] next_seq;
	logic [47:0] sent_time;
	logic [15:0] link_util;
	logic [15:0] queue_packets;
	logic [47:0] echo_time;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [19:0] window_bytes;
	logic [47:0] pace_delay;
	logic [2:0]  send_action;
	logic [1:0]  error_code;

	window_scoreboard sb;
	logic [47:0] flow_time;
	int cycles = 0;
	int stall_mode = 0;
	int stall_hold = 0;

	congestion_window_pacing_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .now(now), .dup_count(dup_count), .inc_flag(inc_flag),
		.ack_number(ack_number), .next_seq(next_seq), .sent_time(sent_time),
		.link_util(link_util), .queue_packets(queue_packets), .echo_time(echo_time),
		.out_valid(out_valid), .out_stall(out_stall),
		.window_bytes(window_bytes), .pace_delay(pace_delay),
		.send_action(send_action), .error_code(error_code)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// transfer monitor on both channels
	always @(posedge clk) begin
		flow_event_t e;
		window_result_t r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				e.act = action; e.now = now; e.dups = dup_count; e.inc = inc_flag;
				e.ackno = ack_number; e.nseq = next_seq; e.sent = sent_time;
				e.util = link_util; e.queue = queue_packets; e.echo = echo_time;
				sb.note(e);
			end
			if (out_valid && !out_stall) begin
				r.win = window_bytes; r.delay = pace_delay;
				r.send = send_action; r.err = error_code;
				sb.check(r);
			end
		end
	end

	// receiver back-pressure, mode is redrawn when the hold counter runs out
	always @(negedge clk) begin
		if (stall_hold == 0) begin
			stall_hold <= $urandom_range(5, 60);
			stall_mode <= $urandom_range(0, 3);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic send_event(flow_event_t e);
		in_valid <= 1'b1;
		action <= e.act; now <= e.now; dup_count <= e.dups; inc_flag <= e.inc;
		ack_number <= e.ackno; next_seq <= e.nseq; sent_time <= e.sent;
		link_util <= e.util; queue_packets <= e.queue; echo_time <= e.echo;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic pause_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write enable stays high across back-to-back writes; configure drops it
	task automatic write_reg(logic [2:0] idx, logic [39:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic configure(logic [13:0] seg, logic [15:0] dfrac, logic [15:0] astep,
			logic froff, logic [39:0] lrate);
		drain();
		write_reg(REG_SEGMENT, 40'(seg));
		write_reg(REG_DECREASE, 40'(dfrac));
		write_reg(REG_ADDITIVE, 40'(astep));
		write_reg(REG_FR_OFF, 40'(froff));
		write_reg(REG_LINK, lrate);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic flow_event_t base_event(logic [2:0] act);
		flow_event_t e;
		flow_time = flow_time + $urandom_range(1, 20000);
		e.act = act; e.now = flow_time; e.dups = '0; e.inc = 1'b0;
		e.ackno = sb.imark[31:0] + 1; e.nseq = sb.imark[31:0] + 3000;
		e.sent = flow_time - $urandom_range(0, 5000);
		e.util = 16'($urandom_range(1, 65535)); e.queue = 16'($urandom_range(1, 65535));
		e.echo = flow_time - $urandom_range(1, 50000);
		return e;
	endfunction

	function automatic flow_event_t random_event();
		flow_event_t e;
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// noise: every field fully random
			e.act = 3'($urandom); e.now = 48'({$urandom, $urandom}); e.dups = 8'($urandom);
			e.inc = 1'($urandom); e.ackno = $urandom; e.nseq = $urandom;
			e.sent = 48'({$urandom, $urandom}); e.util = 16'($urandom);
			e.queue = 16'($urandom);
			e.echo = 48'({$urandom, $urandom});
			return e;
		end
		if ($urandom_range(0, 29) == 0) flow_time = 48'({$urandom, $urandom});
		r = $urandom_range(0, 99);
		if (r < 35) e = base_event(ACT_ACK);
		else if (r < 55) e = base_event(ACT_DUP);
		else if (r < 72) e = base_event(ACT_QUENCH);
		else if (r < 82) e = base_event(ACT_TIMEOUT);
		else if (r < 97) e = base_event(ACT_RTT);
		else e = base_event(3'($urandom_range(5, 7)));
		e.dups = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 4)) : 8'($urandom);
		e.inc = 1'($urandom);
		if ($urandom_range(0, 3) == 0) e.ackno = sb.imark[31:0] - $urandom_range(0, 100);
		if ($urandom_range(0, 9) == 0) e.ackno = $urandom;
		e.nseq = e.ackno + $urandom_range(0, 100000);
		if ($urandom_range(0, 9) == 0) e.sent = e.now + $urandom_range(1, 1000);
		if ($urandom_range(0, 9) == 0) e.util = '0;
		if ($urandom_range(0, 9) == 0) e.queue = '0;
		if ($urandom_range(0, 7) == 0) e.queue = 16'($urandom_range(1, 8));
		if ($urandom_range(0, 11) == 0) e.echo = e.now + $urandom_range(0, 2);
		return e;
	endfunction

	// bursts of random length with random gaps, some stretches gap-free
	task automatic run_random(int n);
		int burst;
		int gapless;
		burst = 0;
		gapless = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				gapless = ($urandom_range(0, 3) == 0);
				if (!gapless) pause_sender($urandom_range(1, 12));
			end
			send_event(random_event());
			burst--;
		end
	endtask

	task automatic run_directed();
		flow_event_t e;
		e = base_event(ACT_ACK); e.inc = 1; send_event(e);
		e = base_event(ACT_ACK); e.ackno = 32'hFFFF_FFFF; e.nseq = 32'hFFFF_FFFF;
		send_event(e);
		e = base_event(ACT_ACK); e.ackno = 0; send_event(e);
		e = base_event(ACT_ACK); e.dups = 3; send_event(e);
		e = base_event(ACT_ACK); e.dups = 8'hFF; send_event(e);
		e = base_event(ACT_DUP); e.dups = 3; send_event(e);
		e = base_event(ACT_DUP); e.dups = 2; send_event(e);
		e = base_event(ACT_DUP); e.dups = 4; send_event(e);
		e = base_event(ACT_RTT); e.echo = e.now; send_event(e);
		e = base_event(ACT_RTT); e.echo = e.now + 5; send_event(e);
		e = base_event(ACT_QUENCH); e.sent = e.now + 10; send_event(e);
		e = base_event(ACT_QUENCH); e.queue = 0; send_event(e);
		e = base_event(ACT_QUENCH); e.util = 0; send_event(e);
		e = base_event(ACT_QUENCH); e.queue = 16'hFFFF; e.util = 16'hFFFF;
		send_event(e);
		e = base_event(ACT_RTT); e.echo = e.now - 20000; send_event(e);
		e = base_event(ACT_QUENCH); e.sent = e.now; send_event(e);
		e = base_event(ACT_TIMEOUT); send_event(e);
		e = base_event(ACT_TIMEOUT); send_event(e);
		e = base_event(ACT_QUENCH); send_event(e);
		e = base_event(3'd5); send_event(e);
		e = base_event(3'd6); send_event(e);
		e = base_event(3'd7); send_event(e);
		e = base_event(ACT_RTT); e.now = TIME_MAX; e.echo = 0; send_event(e);
		e = base_event(ACT_ACK); e.now = TIME_MAX; e.inc = 1; send_event(e);
	endtask

	task automatic run_timeout_storm();
		for (int i = 0; i < 105; i++) begin
			if ($urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 6));
			send_event(base_event(ACT_TIMEOUT));
		end
	endtask

	initial begin
		sb = new();
		flow_time = 48'd1000;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		in_valid = 1'b0;
		action = '0; now = '0; dup_count = '0; inc_flag = 1'b0;
		ack_number = '0; next_seq = '0; sent_time = '0;
		link_util = '0; queue_packets = '0; echo_time = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		run_random(70);
		drain();
		run_random(30);

		configure(14'd1, 16'hFFFF, 16'd0, 1'b0, 40'd0);
		run_random(70);
		configure(14'd9000, 16'd0, 16'hFFFF, 1'b1, 40'hFF_FFFF_FFFF);
		run_random(70);
		configure(14'd0, 16'd1, 16'd1, 1'b0, 40'd1000000000);
		run_random(70);
		configure(14'd536, 16'd49152, 16'd512, 1'b0, 40'd10000000000);
		run_timeout_storm();
		run_random(60);
		configure(14'h3FFF, 16'd32768, 16'd256, 1'b1, 40'd100000000000);
		run_random(70);
		configure(14'd1460, 16'($urandom), 16'($urandom), 1'b0, 40'($urandom));
		run_random(80);

		drain();
		$display("covered %0d ack, %0d dup ack, %0d quench, %0d timeout, %0d rtt events",
			sb.act_count[0], sb.act_count[1], sb.act_count[2], sb.act_count[3],
			sb.act_count[4]);
		$display("%0d results checked over seven register settings, %0d mismatches",
			sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: congestion_window_pacing_engine.f
hw/rtl/cwpe_pkg.sv
hw/rtl/cwpe_mdu.sv
hw/rtl/congestion_window_pacing_engine.sv
bench/testbench.sv
